@@ rtl/core/sfc_pkg.sv @@
`default_nettype none

package sfc_pkg;

	// fixed geometry of the plane registers
	localparam int PLANE_COUNT = 6;
	localparam int SLOT_BITS = 16;
	localparam int PLANE_BITS = 64;
	localparam int RADIUS_BITS = 15;
	localparam int VERDICT_BITS = 2;

	// parameter defaults
	localparam int COORD_BITS_DEF = 16;
	localparam int NORMAL_FRAC_BITS_DEF = 14;

	// configuration port
	localparam int ADDR_BITS = 6;
	localparam int REG_IDX_BITS = 3;
	localparam int REG_IDX_LSB = 3;

	localparam logic [REG_IDX_BITS-1:0] REG_PLANE_RIGHT = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_PLANE_LEFT = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_PLANE_BOTTOM = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_PLANE_TOP = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_PLANE_BACK = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_PLANE_FRONT = 3'd5;

	// verdict codes
	localparam logic [VERDICT_BITS-1:0] VERDICT_OUTSIDE = 2'd0;
	localparam logic [VERDICT_BITS-1:0] VERDICT_INTERSECT = 2'd1;
	localparam logic [VERDICT_BITS-1:0] VERDICT_INSIDE = 2'd2;

	typedef logic [PLANE_BITS-1:0] plane_reg_t;

	// per-stage load enables of the distance pipeline
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} stage_en_t;

	// width of an exact distance in units of 2^-frac
	function automatic int dist_bits(int coord_bits, int frac_bits);
		int w;
		w = (coord_bits > frac_bits) ? coord_bits : frac_bits;
		return SLOT_BITS + w + 2;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/sphere_frustum_classifier_unit.sv @@
`default_nettype none

// Classifies a bounding sphere against six frustum planes held in 64-bit
// registers (a, b, c in Q1.14 at bits 47:0, d signed at bits 63:48, normals
// pointing inward) and returns verdict 0 outside, 1 intersecting, 2 inside;
// a radius of zero gives a point test. Distances are exact, nothing rounds
// or saturates. The block takes one request every clock cycle unless the
// output stalls. Stages: eighteen 16-bit by coordinate multipliers; the
// pairwise sums and full distance of each plane; the radius compares and
// the verdict register, which also serves as the output register. Stalls
// on the output back up stage by stage, so bubbles still in the pipeline
// keep taking requests. Planes sit at byte addresses 8*i in the order
// right, left, bottom, top, back, front; all reset to zero. Users must
// write them only while no request is in flight, which is not enforced.
module sphere_frustum_classifier_unit #(
	parameter int COORD_BITS = sfc_pkg::COORD_BITS_DEF,
	parameter int NORMAL_FRAC_BITS = sfc_pkg::NORMAL_FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [sfc_pkg::ADDR_BITS-1:0]         paddr,
	input  wire logic [sfc_pkg::PLANE_BITS-1:0]        pwdata,
	output logic      [sfc_pkg::PLANE_BITS-1:0]        prdata,
	output logic                                       pready,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [COORD_BITS-1:0]          center_x,
	input  wire logic signed [COORD_BITS-1:0]          center_y,
	input  wire logic signed [COORD_BITS-1:0]          center_z,
	input  wire logic [sfc_pkg::RADIUS_BITS-1:0]       sphere_radius,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [sfc_pkg::VERDICT_BITS-1:0]           verdict
);

	localparam int NP = sfc_pkg::PLANE_COUNT;
	localparam int DIST_BITS = sfc_pkg::dist_bits(COORD_BITS, NORMAL_FRAC_BITS);
	localparam int RSC_BITS = sfc_pkg::RADIUS_BITS + NORMAL_FRAC_BITS;

	sfc_pkg::plane_reg_t [NP-1:0] planes;
	sfc_pkg::stage_en_t           en;
	logic                         en_s4;
	logic                         v_s1, v_s2, v_s3, v_s4;
	logic [RSC_BITS-1:0]          rsc_s1, rsc_s2;
	logic signed [DIST_BITS-1:0]  rpos_s3, rneg_s3;
	logic signed [DIST_BITS-1:0]  pdist [NP];
	logic [NP-1:0]                out_hit, le_hit;
	logic [sfc_pkg::VERDICT_BITS-1:0] verdict_nxt, verdict_s4;

	assign pready = 1'b1;

	sfc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.planes  (planes)
	);

	// stall chain from the output back to the input
	assign en_s4 = !v_s4 || out_ready;
	assign en.en_s3 = !v_s3 || en_s4;
	assign en.en_s2 = !v_s2 || en.en_s3;
	assign en.en_s1 = !v_s1 || en.en_s2;
	assign in_ready = en.en_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.en_s1) v_s1 <= in_valid;
			if (en.en_s2) v_s2 <= v_s1;
			if (en.en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// per-plane distance pipelines
	for (genvar i = 0; i < NP; i++) begin : g_plane
		sfc_plane_dist #(
			.COORD_BITS       (COORD_BITS),
			.NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
			.DIST_BITS        (DIST_BITS)
		) u_dist (
			.clk      (clk),
			.en       (en),
			.plane    (planes[i]),
			.x        (center_x),
			.y        (center_y),
			.z        (center_z),
			.distance (pdist[i])
		);
	end

	// radius travels alongside, scaled to the normal fraction
	always_ff @(posedge clk) begin
		if (en.en_s1) rsc_s1 <= {sphere_radius, {NORMAL_FRAC_BITS{1'b0}}};
		if (en.en_s2) rsc_s2 <= rsc_s1;
		if (en.en_s3) begin
			rpos_s3 <= DIST_BITS'(rsc_s2);
			rneg_s3 <= -DIST_BITS'(rsc_s2);
		end
	end

	// radius compares and verdict
	always_comb begin
		for (int i = 0; i < NP; i++) begin
			out_hit[i] = pdist[i] <= rneg_s3;
			le_hit[i] = pdist[i] <= rpos_s3;
		end
		if (|out_hit) verdict_nxt = sfc_pkg::VERDICT_OUTSIDE;
		else if (|le_hit) verdict_nxt = sfc_pkg::VERDICT_INTERSECT;
		else verdict_nxt = sfc_pkg::VERDICT_INSIDE;
	end

	always_ff @(posedge clk) begin
		if (en_s4) verdict_s4 <= verdict_nxt;
	end

	assign out_valid = v_s4;
	assign verdict = verdict_s4;

`ifndef SYNTHESIS
	// a taken request lands in the first stage
	a_take_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("request taken but first stage empty");

	// a blocked first stage keeps its item
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en.en_s2 |=> v_s1 && $stable(rsc_s1))
		else $error("stalled first stage lost its item");

	// an item leaving stage three reaches the output
	a_move_s4: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en_s4 |=> out_valid)
		else $error("item dropped between distance and verdict stages");

	// an empty output stage never blocks the input
	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s4 |-> in_ready)
		else $error("input blocked with an empty output stage");

	// verdict code three is never shown
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> verdict != 2'd3)
		else $error("invalid verdict code");
`endif

endmodule

`default_nettype wire

@@ rtl/core/sfc_regs.sv @@
`default_nettype none

module sfc_regs (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       psel,
	input  wire logic                                       penable,
	input  wire logic                                       pwrite,
	input  wire logic [sfc_pkg::ADDR_BITS-1:0]              paddr,
	input  wire logic [sfc_pkg::PLANE_BITS-1:0]             pwdata,
	output logic      [sfc_pkg::PLANE_BITS-1:0]             prdata,
	output sfc_pkg::plane_reg_t [sfc_pkg::PLANE_COUNT-1:0]  planes
);

	logic [sfc_pkg::REG_IDX_BITS-1:0] idx;
	logic                             wr;
	sfc_pkg::plane_reg_t [sfc_pkg::PLANE_COUNT-1:0] planes_q;

	assign idx = paddr[sfc_pkg::ADDR_BITS-1:sfc_pkg::REG_IDX_LSB];
	assign wr = psel & penable & pwrite;
	assign planes = planes_q;

	// register writes, out-of-range index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_q <= '0;
		end else if (wr) begin
			case (idx)
				sfc_pkg::REG_PLANE_RIGHT:  planes_q[0] <= pwdata;
				sfc_pkg::REG_PLANE_LEFT:   planes_q[1] <= pwdata;
				sfc_pkg::REG_PLANE_BOTTOM: planes_q[2] <= pwdata;
				sfc_pkg::REG_PLANE_TOP:    planes_q[3] <= pwdata;
				sfc_pkg::REG_PLANE_BACK:   planes_q[4] <= pwdata;
				sfc_pkg::REG_PLANE_FRONT:  planes_q[5] <= pwdata;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			sfc_pkg::REG_PLANE_RIGHT:  prdata = planes_q[0];
			sfc_pkg::REG_PLANE_LEFT:   prdata = planes_q[1];
			sfc_pkg::REG_PLANE_BOTTOM: prdata = planes_q[2];
			sfc_pkg::REG_PLANE_TOP:    prdata = planes_q[3];
			sfc_pkg::REG_PLANE_BACK:   prdata = planes_q[4];
			sfc_pkg::REG_PLANE_FRONT:  prdata = planes_q[5];
			default:                   prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/sfc_plane_dist.sv @@
`default_nettype none

module sfc_plane_dist #(
	parameter int COORD_BITS = sfc_pkg::COORD_BITS_DEF,
	parameter int NORMAL_FRAC_BITS = sfc_pkg::NORMAL_FRAC_BITS_DEF,
	parameter int DIST_BITS = sfc_pkg::dist_bits(COORD_BITS, NORMAL_FRAC_BITS)
) (
	input  wire logic                         clk,
	input  wire sfc_pkg::stage_en_t           en,
	input  wire sfc_pkg::plane_reg_t          plane,
	input  wire logic signed [COORD_BITS-1:0] x,
	input  wire logic signed [COORD_BITS-1:0] y,
	input  wire logic signed [COORD_BITS-1:0] z,
	output logic signed [DIST_BITS-1:0]       distance
);

	localparam int SB = sfc_pkg::SLOT_BITS;
	localparam int PROD_BITS = SB + COORD_BITS;
	localparam int DSC_BITS = SB + NORMAL_FRAC_BITS;

	logic signed [SB-1:0] a, b, c, d;
	logic signed [PROD_BITS-1:0] pa_s1, pb_s1, pc_s1;
	logic signed [DSC_BITS-1:0] dsc_s1;
	logic signed [DIST_BITS-1:0] sab_s2, scd_s2, dist_s3;

	// slots of the packed plane word
	assign a = plane[SB-1:0];
	assign b = plane[2*SB-1:SB];
	assign c = plane[3*SB-1:2*SB];
	assign d = plane[4*SB-1:3*SB];

	// stage 1: normal times coordinate, d scaled to the normal fraction
	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			pa_s1 <= PROD_BITS'(a) * PROD_BITS'(x);
			pb_s1 <= PROD_BITS'(b) * PROD_BITS'(y);
			pc_s1 <= PROD_BITS'(c) * PROD_BITS'(z);
			dsc_s1 <= {d, {NORMAL_FRAC_BITS{1'b0}}};
		end
	end

	// stage 2: pairwise sums
	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			sab_s2 <= DIST_BITS'(pa_s1) + DIST_BITS'(pb_s1);
			scd_s2 <= DIST_BITS'(pc_s1) + DIST_BITS'(dsc_s1);
		end
	end

	// stage 3: full distance
	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			dist_s3 <= sab_s2 + scd_s2;
		end
	end

	assign distance = dist_s3;

endmodule

`default_nettype wire
